FILE: hw/rtl/lta_pkg.sv
// Shared types and constants for the lottery arbiter.
`default_nettype none
package lta_pkg;

   localparam int SLOT_IN_W = 6;
   localparam int TICKET_W  = 16;
   localparam int TIME_W    = 32;
   localparam int SEED_W    = 32;
   localparam int DIV_STEPS = SEED_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [SEED_W-1:0] LCG_INC = 32'd1013904223;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PICK  = 1'b1;

   typedef struct packed {
      logic                ready;
      logic [TICKET_W-1:0] tickets;
      logic [TIME_W-1:0]   arrival;
   } slot_entry_type;

   localparam slot_entry_type SLOT_RESET = '{ready: 1'b0, tickets: 16'd1, arrival: 32'd0};

endpackage
`default_nettype wire

FILE: hw/rtl/lta_table.sv
// Slot table memory: one write port, one registered read port.
`default_nettype none
module lta_table #(
   parameter int SLOTS = 64,
   parameter int IDX_W = 6
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire [IDX_W-1:0]              wr_addr,
   input  wire lta_pkg::slot_entry_type wr_data,
   input  wire [IDX_W-1:0]              rd_addr,
   output lta_pkg::slot_entry_type      rd_data
);

   lta_pkg::slot_entry_type mem [SLOTS];
   lta_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/lta_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one bit per cycle.
`default_nettype none
module lta_mod #(
   parameter int SUM_W = 22
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [lta_pkg::SEED_W-1:0]  dividend,
   input  wire [SUM_W-1:0]            divisor,
   output logic                       done,
   output logic [SUM_W-1:0]           remainder
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [lta_pkg::STEP_W-1:0]  cnt_ff;
   logic [lta_pkg::SEED_W-1:0]  quo_ff;
   logic [SUM_W-1:0]            rem_ff;
   logic [SUM_W:0]              shifted;
   logic [SUM_W-1:0]            rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[lta_pkg::SEED_W-1]};
      if (shifted >= {1'b0, divisor}) begin
         rem_in = SUM_W'(shifted - {1'b0, divisor});
      end else begin
         rem_in = SUM_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[lta_pkg::SEED_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == lta_pkg::STEP_W'(lta_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/lottery_arbiter_with_arrival_tiebreak.sv
// Lottery arbiter with arrival-time tiebreak: sequencer and top level.
// Write item: taken while idle, busy stays low, no result.
// Pick item: busy through the sum scan, LCG step, divider start, serial modulo, draw walk and
// tiebreak scan, in that order; it ends after the sum scan when no ready slot holds tickets.
// The result strobes in the first cycle with busy low; the next item may be taken at its end.
// After reset a pass loads every slot with its reset value; busy is high during it.
`default_nettype none
module lottery_arbiter_with_arrival_tiebreak #(
   parameter int SLOTS = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_op,
   input  wire  [5:0]  req_slot,
   input  wire         req_ready_req,
   input  wire  [15:0] req_tickets,
   input  wire  [31:0] req_arrival,
   input  wire  [31:0] req_seed,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [5:0]  rsp_winner
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int SUM_W = lta_pkg::TICKET_W + IDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SUM, S_LCG, S_DIV_GO, S_DIV, S_WALK, S_TIE
   } state_type;

   state_type                       state_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic                            dv_ff;
   logic [IDX_W-1:0]                di_ff;
   logic [lta_pkg::SEED_W-1:0]      seed_ff;
   logic [lta_pkg::SEED_W-1:0]      lcg_ff;
   logic [lta_pkg::SEED_W-1:0]      lcg_in;
   logic [SUM_W-1:0]                sum_ff;
   logic [SUM_W-1:0]                sum_in;
   logic [SUM_W-1:0]                run_ff;
   logic [SUM_W-1:0]                draw_ff;
   logic [SUM_W:0]                  run_tk;
   logic [IDX_W-1:0]                win_ff;
   logic [IDX_W-1:0]                win_in;
   logic [lta_pkg::TICKET_W-1:0]    want_ff;
   logic [lta_pkg::TIME_W-1:0]      best_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;
   logic [5:0]                      rsp_winner_ff;

   logic                            accept;
   logic                            wr_en;
   logic [IDX_W-1:0]                wr_addr;
   lta_pkg::slot_entry_type         wr_data;
   lta_pkg::slot_entry_type         rd_data;
   logic [SUM_W-1:0]                contrib;
   logic                            walk_hit;
   logic                            tie_hit;
   logic                            div_done;
   logic [SUM_W-1:0]                div_rem;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = lta_pkg::SLOT_RESET;
      end else begin
         wr_en   = accept && (req_op == lta_pkg::OP_WRITE) &&
                   ({26'd0, req_slot} < 32'(SLOTS));
         wr_addr = IDX_W'(req_slot);
         wr_data = '{ready: req_ready_req, tickets: req_tickets, arrival: req_arrival};
      end
   end

   lta_table #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   lta_mod #(
      .SUM_W (SUM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_DIV_GO),
      .dividend  (lcg_ff),
      .divisor   (sum_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      contrib  = rd_data.ready ? SUM_W'(rd_data.tickets) : '0;
      sum_in   = sum_ff + contrib;
      run_tk   = {1'b0, run_ff} + (SUM_W + 1)'(rd_data.tickets);
      walk_hit = rd_data.ready && ({1'b0, draw_ff} <= run_tk);
      tie_hit  = rd_data.ready && (rd_data.tickets == want_ff) &&
                 (rd_data.arrival < best_ff);
      win_in   = tie_hit ? di_ff : win_ff;
      lcg_in   = seed_ff * lta_pkg::LCG_MUL + lta_pkg::LCG_INC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         if (state_ff == S_SUM || state_ff == S_WALK || state_ff == S_TIE) begin
            dv_ff <= 1'b1;
            di_ff <= idx_ff;
            if (idx_ff != LAST_IDX) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept && req_op == lta_pkg::OP_PICK) begin
                  seed_ff  <= req_seed;
                  sum_ff   <= '0;
                  idx_ff   <= '0;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (dv_ff) begin
                  sum_ff <= sum_in;
                  if (di_ff == LAST_IDX) begin
                     if (sum_in == '0) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_found_ff  <= 1'b0;
                        rsp_winner_ff <= '0;
                        state_ff      <= S_IDLE;
                     end else begin
                        state_ff <= S_LCG;
                     end
                  end
               end
            end
            S_LCG: begin
               lcg_ff   <= lcg_in;
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  draw_ff  <= SUM_W'(div_rem + 1'b1);
                  run_ff   <= '0;
                  idx_ff   <= '0;
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (dv_ff) begin
                  if (walk_hit) begin
                     win_ff   <= di_ff;
                     want_ff  <= rd_data.tickets;
                     best_ff  <= rd_data.arrival;
                     idx_ff   <= '0;
                     dv_ff    <= 1'b0;
                     state_ff <= S_TIE;
                  end else begin
                     run_ff <= SUM_W'(run_ff + contrib);
                     if (di_ff == LAST_IDX) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_found_ff  <= 1'b0;
                        rsp_winner_ff <= '0;
                        state_ff      <= S_IDLE;
                     end
                  end
               end
            end
            S_TIE: begin
               if (dv_ff) begin
                  win_ff <= win_in;
                  if (tie_hit) begin
                     best_ff <= rd_data.arrival;
                  end
                  if (di_ff == LAST_IDX) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_found_ff  <= 1'b1;
                     rsp_winner_ff <= 6'(win_in);
                     idx_ff        <= '0;
                     state_ff      <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_winner = rsp_winner_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_pick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == lta_pkg::OP_PICK) |=> busy)
      else $error("pick item did not start the sequencer");

   a_no_win_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_winner == '0))
      else $error("winner nonzero without a winner");

   a_draw_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (draw_ff != '0 && draw_ff <= sum_ff))
      else $error("draw outside ticket sum");

endmodule
`default_nettype wire
